>>> design/bdda_pkg.sv
// Shared types, constants and calendar helper functions for the business-day date adder.
`default_nettype none

package bdda_pkg;

   // field widths
   localparam int YEAR_W  = 14;
   localparam int MONTH_W = 4;
   localparam int DAY_W   = 5;
   localparam int WDAY_W  = 3;
   localparam int COUNT_W = 15;
   localparam int ERR_W   = 2;
   localparam int MASK_W  = 7;
   localparam int CENT_W  = 8;
   localparam int R100_W  = 7;

   localparam logic [MASK_W-1:0] MASK_RESET = 7'd96;
   localparam logic [MASK_W-1:0] MASK_ALL   = 7'h7F;
   localparam logic [YEAR_W-1:0] YEAR_MAX   = 14'd16383;

   // error codes
   localparam logic [ERR_W-1:0] ERR_OK       = 2'd0;
   localparam logic [ERR_W-1:0] ERR_BAD_DATE = 2'd1;
   localparam logic [ERR_W-1:0] ERR_NO_WORK  = 2'd2;
   localparam logic [ERR_W-1:0] ERR_OVERFLOW = 2'd3;

   // year / 100 as (year * 5243) >> 19, exact for every 14-bit year
   localparam int                DIV100_MUL_W = 13;
   localparam logic [12:0]       DIV100_MUL   = 13'd5243;
   localparam int                DIV100_SHIFT = 19;
   localparam int                PROD_W       = YEAR_W + DIV100_MUL_W;

   typedef struct packed {
      logic [YEAR_W-1:0]  year;
      logic [MONTH_W-1:0] month;
      logic [DAY_W-1:0]   day;
      logic [WDAY_W-1:0]  weekday;
      logic [R100_W-1:0]  yr_mod100;   // year mod 100
      logic [1:0]         cent_mod4;   // (year / 100) mod 4
   } date_type;

   // Gregorian leap rule from year mod 100 and century mod 4
   function automatic logic is_leap(input logic [R100_W-1:0] r100, input logic [1:0] c4);
      return ((r100 != '0) && (r100[1:0] == 2'd0)) || ((r100 == '0) && (c4 == 2'd0));
   endfunction

   // length of a month, zero for a month code outside January..December
   function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] month,
                                                input logic leap);
      logic [DAY_W-1:0] len;
      case (month)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
         4'd2:                                       len = leap ? 5'd29 : 5'd28;
         default:                                    len = 5'd0;
      endcase
      return len;
   endfunction

   // (31 * mm) / 12 for the March-based month number mm
   function automatic logic [DAY_W-1:0] month_offset(input logic [MONTH_W-1:0] mm);
      logic [DAY_W-1:0] off;
      case (mm)
         4'd1:    off = 5'd2;
         4'd2:    off = 5'd5;
         4'd3:    off = 5'd7;
         4'd4:    off = 5'd10;
         4'd5:    off = 5'd12;
         4'd6:    off = 5'd15;
         4'd7:    off = 5'd18;
         4'd8:    off = 5'd20;
         4'd9:    off = 5'd23;
         4'd10:   off = 5'd25;
         4'd11:   off = 5'd28;
         4'd12:   off = 5'd31;
         default: off = 5'd0;
      endcase
      return off;
   endfunction

   // value mod 7 by folding octal digits (8 is 1 mod 7)
   function automatic logic [WDAY_W-1:0] mod7(input logic [15:0] val);
      logic [5:0] fold1;
      logic [3:0] fold2;
      fold1 = 6'(val[2:0]) + 6'(val[5:3]) + 6'(val[8:6]) + 6'(val[11:9])
            + 6'(val[14:12]) + 6'(val[15]);
      fold2 = 4'(fold1[2:0]) + 4'(fold1[5:3]);
      if (fold2 >= 4'd7) begin
         fold2 = fold2 - 4'd7;
      end
      return fold2[2:0];
   endfunction

endpackage

`default_nettype wire

>>> design/bdda_day_step.sv
// Advances a calendar date by one day with month/year rollover and weekday update.
`default_nettype none

module bdda_day_step
   import bdda_pkg::*;
(
   input  date_type cur_date,
   output date_type next_date,
   output logic     year_overflow
);

   logic             leap;
   logic [DAY_W-1:0] month_len;

   assign leap      = is_leap(cur_date.yr_mod100, cur_date.cent_mod4);
   assign month_len = days_in(cur_date.month, leap);

   // step day, roll month and year at their ends
   always_comb begin
      next_date     = cur_date;
      year_overflow = 1'b0;
      if (cur_date.day >= month_len) begin
         next_date.day = 5'd1;
         if (cur_date.month >= 4'd12) begin
            next_date.month = 4'd1;
            if (cur_date.year == YEAR_MAX) begin
               year_overflow = 1'b1;
            end else begin
               next_date.year = cur_date.year + 14'd1;
            end
            if (cur_date.yr_mod100 == 7'd99) begin
               next_date.yr_mod100 = 7'd0;
               next_date.cent_mod4 = cur_date.cent_mod4 + 2'd1;
            end else begin
               next_date.yr_mod100 = cur_date.yr_mod100 + 7'd1;
            end
         end else begin
            next_date.month = cur_date.month + 4'd1;
         end
      end else begin
         next_date.day = cur_date.day + 5'd1;
      end
      next_date.weekday = (cur_date.weekday == 3'd6) ? 3'd0 : cur_date.weekday + 3'd1;
   end

endmodule

`default_nettype wire

>>> design/business_day_date_adder_unit.sv
// Business-day date adder: top level with request sequencer and result register.
// Usage:
//   req channel carries a start date and a count of working days. One
//   transfer starts a walk; req_tready is low until its result is loaded.
//   rsp channel carries the return date, its weekday and an error code in
//   rsp_tuser. Exactly one rsp transfer follows each req transfer.
//   csr channel writes the 7-bit weekend mask (bit n marks weekday n,
//   0 Sunday, as weekend); csr_ready is always high. Write it only while idle.
// Timing:
//   Setup runs two passes of the shared divide-by-100 multiplier, the weekday
//   sum and the mod-7 fold; the shared day-step unit then walks one calendar
//   day per cycle, the walk end is seen in WALK and DONE loads the result
//   register. rsp_tvalid rises together with req_tready, so a request holds
//   the unit until its result is loaded. Ten working days walk about 14 days.
//   A bad date or an all-weekend mask skips fold and walk.
// Reset: synchronous, clears the sequencer and rsp_tvalid and sets the mask
//   to Friday and Saturday.
// Stall: a finished result waits in the rsp register; a new request is
//   accepted meanwhile, but its own result waits until the register frees.
`default_nettype none

module business_day_date_adder_unit
   import bdda_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // [13:0] start_year, [17:14] start_month, [22:18] start_day,
   // [37:23] working_days, [39:38] zero
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,
   // [13:0] return_year, [17:14] return_month, [22:18] return_day,
   // [25:23] return_weekday, [31:26] zero
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,
   // [1:0] error_code
   output logic [1:0]       rsp_tuser,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [6:0]  csr_data
);

   // sequencer states
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DIV_Y  = 3'd1;
   localparam logic [2:0] ST_DIV_YY = 3'd2;
   localparam logic [2:0] ST_SUM    = 3'd3;
   localparam logic [2:0] ST_MOD    = 3'd4;
   localparam logic [2:0] ST_WALK   = 3'd5;
   localparam logic [2:0] ST_DONE   = 3'd6;

   logic [2:0]          state_ff, state_in;
   logic [MASK_W-1:0]   mask_ff;

   // latched request
   logic [YEAR_W-1:0]   in_year_ff;
   logic [MONTH_W-1:0]  in_month_ff;
   logic [DAY_W-1:0]    in_day_ff;
   logic [COUNT_W-1:0]  in_count_ff;
   logic [YEAR_W-1:0]   yy_ff;
   logic [MONTH_W-1:0]  mm_ff;

   // setup results
   logic [CENT_W-1:0]   cent_y_ff;
   logic [CENT_W-1:0]   cent_yy_ff;
   logic [15:0]         sum_ff;

   // walk state
   date_type            walk_ff;
   logic [COUNT_W-1:0]  remain_ff;
   logic [ERR_W-1:0]    err_ff;

   // result register
   logic                rsp_valid_ff;
   logic [YEAR_W-1:0]   rsp_year_ff;
   logic [MONTH_W-1:0]  rsp_month_ff;
   logic [DAY_W-1:0]    rsp_day_ff;
   logic [WDAY_W-1:0]   rsp_wday_ff;
   logic [ERR_W-1:0]    rsp_err_ff;

   logic                req_xfer;
   logic                rsp_load;
   logic                req_a;
   logic [YEAR_W-1:0]   mul_op;
   logic [PROD_W-1:0]   mul_prod;
   logic [CENT_W-1:0]   mul_quo;
   logic [YEAR_W-1:0]   r100_full;
   logic                start_leap;
   logic                date_bad;
   logic                weekend_now;
   date_type            step_date;
   logic                step_ovf;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_load   = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);

   // January and February count as months 11 and 12 of the previous year
   assign req_a = (req_tdata[17:14] == 4'd1) || (req_tdata[17:14] == 4'd2);

   // shared divide-by-100 multiplier
   assign mul_op   = (state_ff == ST_DIV_Y) ? in_year_ff : yy_ff;
   assign mul_prod = PROD_W'(mul_op) * PROD_W'(DIV100_MUL);
   assign mul_quo  = mul_prod[DIV100_SHIFT +: CENT_W];

   // start date check
   assign r100_full  = in_year_ff - (YEAR_W'(cent_y_ff) * 14'd100);
   assign start_leap = is_leap(r100_full[R100_W-1:0], cent_y_ff[1:0]);
   assign date_bad   = (in_year_ff == '0) || (in_month_ff == '0) || (in_month_ff > 4'd12)
                    || (in_day_ff == '0) || (in_day_ff > days_in(in_month_ff, start_leap));

   assign weekend_now = mask_ff[walk_ff.weekday];

   bdda_day_step u_step (
      .cur_date      (walk_ff),
      .next_date     (step_date),
      .year_overflow (step_ovf)
   );

   // control: state, mask, result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mask_ff      <= MASK_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            mask_ff <= csr_data;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_xfer) state_in = ST_DIV_Y;
         ST_DIV_Y:  state_in = ST_DIV_YY;
         ST_DIV_YY: state_in = ST_SUM;
         ST_SUM:    state_in = (date_bad || (mask_ff == MASK_ALL)) ? ST_DONE : ST_MOD;
         ST_MOD:    state_in = ST_WALK;
         ST_WALK: begin
            if (remain_ff != '0 || weekend_now) begin
               if (step_ovf) state_in = ST_DONE;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE:   if (rsp_load) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // datapath: latch request, run setup, walk days
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               in_year_ff  <= req_tdata[13:0];
               in_month_ff <= req_tdata[17:14];
               in_day_ff   <= req_tdata[22:18];
               in_count_ff <= req_tdata[37:23];
               yy_ff       <= req_tdata[13:0] - YEAR_W'(req_a);
               mm_ff       <= req_a ? req_tdata[17:14] + 4'd10 : req_tdata[17:14] - 4'd2;
               err_ff      <= ERR_OK;
            end
         end
         ST_DIV_Y:  cent_y_ff  <= mul_quo;
         ST_DIV_YY: cent_yy_ff <= mul_quo;
         ST_SUM: begin
            if (date_bad) begin
               err_ff <= ERR_BAD_DATE;
            end else if (mask_ff == MASK_ALL) begin
               err_ff <= ERR_NO_WORK;
            end
            walk_ff.year      <= in_year_ff;
            walk_ff.month     <= in_month_ff;
            walk_ff.day       <= in_day_ff;
            walk_ff.yr_mod100 <= r100_full[R100_W-1:0];
            walk_ff.cent_mod4 <= cent_y_ff[1:0];
            remain_ff         <= in_count_ff;
            sum_ff <= 16'(in_day_ff) + 16'(yy_ff) + 16'(yy_ff[YEAR_W-1:2])
                    - 16'(cent_yy_ff) + 16'(cent_yy_ff[CENT_W-1:2])
                    + 16'(month_offset(mm_ff));
         end
         ST_MOD: walk_ff.weekday <= mod7(sum_ff);
         ST_WALK: begin
            if (remain_ff != '0 || weekend_now) begin
               if (remain_ff != '0 && !weekend_now) begin
                  remain_ff <= remain_ff - 15'd1;
               end
               if (step_ovf) begin
                  err_ff <= ERR_OVERFLOW;
               end else begin
                  walk_ff <= step_date;
               end
            end
         end
         default: ;
      endcase
   end

   // result register: zero date fields on error
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_err_ff <= err_ff;
         if (err_ff == ERR_OK) begin
            rsp_year_ff  <= walk_ff.year;
            rsp_month_ff <= walk_ff.month;
            rsp_day_ff   <= walk_ff.day;
            rsp_wday_ff  <= walk_ff.weekday;
         end else begin
            rsp_year_ff  <= '0;
            rsp_month_ff <= '0;
            rsp_day_ff   <= '0;
            rsp_wday_ff  <= '0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_wday_ff, rsp_day_ff, rsp_month_ff, rsp_year_ff};
   assign rsp_tuser  = rsp_err_ff;

endmodule

`default_nettype wire

>>> tb/tb_business_day_date_adder_unit.sv
// Self-checking testbench for the business-day date adder: stream stimulus, predictor, checker.
`default_nettype none

module tb_business_day_date_adder_unit
   import bdda_pkg::*;
();

   localparam int STALL_LIMIT = 400000;
   localparam int MAX_REPORTS = 10;
   localparam int HOLD_CYCLES = 300;

   // one request: start date and working days, laid out as on req_tdata
   typedef struct packed {
      logic [COUNT_W-1:0] work;
      logic [DAY_W-1:0]   day;
      logic [MONTH_W-1:0] month;
      logic [YEAR_W-1:0]  year;
   } trip_type;

   // one result: return date, weekday and error code, as {rsp_tuser, rsp_tdata[25:0]}
   typedef struct packed {
      logic [ERR_W-1:0]   err;
      logic [WDAY_W-1:0]  weekday;
      logic [DAY_W-1:0]   day;
      logic [MONTH_W-1:0] month;
      logic [YEAR_W-1:0]  year;
   } landing_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [39:0]       req_tdata = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [31:0]       rsp_tdata;
   logic [1:0]        rsp_tuser;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [MASK_W-1:0] csr_data = '0;

   trip_type          pending_trips[$];
   landing_type       expected_landings[$];
   logic [MASK_W-1:0] mask_now = MASK_RESET;
   int                trips_queued = 0;
   int                req_acc_cnt = 0;
   int                rsp_acc_cnt = 0;
   int                fail_count = 0;
   int                quiet_cycles = 0;
   bit                rsp_hold = 1'b0;

   // driver and receiver pacing
   int                req_seen = 0;
   int                send_gap = 0;
   bit                send_steady = 1'b0;
   int                rsp_seen = 0;
   int                recv_wait = 0;
   bit                recv_steady = 1'b0;

   business_day_date_adder_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #1 clock = ~clock;

   // Gregorian month length, zero for a bad month code
   function automatic int month_days(int m, int y);
      bit leap;
      leap = (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
      case (m)
         1, 3, 5, 7, 8, 10, 12: return 31;
         4, 6, 9, 11:           return 30;
         2:                     return leap ? 29 : 28;
         default:               return 0;
      endcase
   endfunction

   // compute the return date for one trip under the given weekend mask
   function automatic landing_type predict_landing(trip_type t, logic [MASK_W-1:0] mask);
      int          y, m, d, wd, left, a, yy, mm;
      landing_type res;
      y    = t.year;
      m    = t.month;
      d    = t.day;
      left = t.work;
      res  = '0;
      if (y == 0 || m < 1 || m > 12 || d == 0 || d > month_days(m, y)) begin
         res.err = ERR_BAD_DATE;
         return res;
      end
      if (mask == MASK_ALL) begin
         res.err = ERR_NO_WORK;
         return res;
      end
      // weekday of the start date, March-based months
      a  = (14 - m) / 12;
      yy = y - a;
      mm = m + 12 * a - 2;
      wd = (d + yy + yy / 4 - yy / 100 + yy / 400 + (31 * mm) / 12) % 7;
      // spend the working days, then slide off any weekend
      while (left > 0 || mask[wd]) begin
         if (!mask[wd]) begin
            left--;
         end
         if (d >= month_days(m, y)) begin
            if (m == 12) begin
               if (y >= YEAR_MAX) begin
                  res.err = ERR_OVERFLOW;
                  return res;
               end
               y++;
               m = 1;
            end else begin
               m++;
            end
            d = 1;
         end else begin
            d++;
         end
         wd = (wd + 1) % 7;
      end
      res.year    = YEAR_W'(y);
      res.month   = MONTH_W'(m);
      res.day     = DAY_W'(d);
      res.weekday = WDAY_W'(wd);
      res.err     = ERR_OK;
      return res;
   endfunction

   // random trip: mostly well-formed dates, some near the top year or century
   // corners, about one in twelve broken
   function automatic trip_type draw_trip(int work_per_week);
      trip_type t;
      int       kind;
      int       pick;
      pick = $urandom_range(0, 63);
      if (pick == 0 && work_per_week >= 3) begin
         t.work = COUNT_W'($urandom_range(0, 32767));
      end else if (pick < 8) begin
         t.work = COUNT_W'($urandom_range(0, 1023));
      end else begin
         t.work = COUNT_W'($urandom_range(0, 24));
      end
      kind = $urandom_range(0, 15);
      if (kind == 0) begin
         t.year  = YEAR_MAX;
         t.month = 4'd12;
         t.day   = DAY_W'($urandom_range(15, 31));
      end else if (kind < 3) begin
         case ($urandom_range(0, 4))
            0:       t.year = 14'd1600;
            1:       t.year = 14'd1900;
            2:       t.year = 14'd2000;
            3:       t.year = 14'd2100;
            default: t.year = 14'd10000;
         endcase
         t.month = $urandom_range(0, 1) ? 4'd2 : 4'd12;
         t.day   = DAY_W'($urandom_range(1, month_days(t.month, t.year)));
      end else begin
         t.year  = YEAR_W'($urandom_range(1, 16383));
         t.month = MONTH_W'($urandom_range(1, 12));
         t.day   = DAY_W'($urandom_range(1, month_days(t.month, t.year)));
      end
      if ($urandom_range(0, 11) == 0) begin
         case ($urandom_range(0, 4))
            0:       t.year  = '0;
            1:       t.month = '0;
            2:       t.month = MONTH_W'($urandom_range(13, 15));
            3:       t.day   = '0;
            default: begin
               t.month = $urandom_range(0, 1) ? 4'd2 : 4'd11;
               t.day   = DAY_W'($urandom_range(month_days(t.month, t.year) + 1, 31));
            end
         endcase
      end
      return t;
   endfunction

   task automatic queue_trip(int y, int m, int d, int n);
      trip_type t;
      t.year  = YEAR_W'(y);
      t.month = MONTH_W'(m);
      t.day   = DAY_W'(d);
      t.work  = COUNT_W'(n);
      pending_trips.push_back(t);
      trips_queued++;
   endtask

   task automatic queue_random(int count);
      for (int i = 0; i < count; i++) begin
         pending_trips.push_back(draw_trip(7 - $countones(mask_now)));
         trips_queued++;
      end
   endtask

   // hold the stimulus until every queued trip has been sent and has come back
   task automatic settle();
      wait (req_acc_cnt == trips_queued && rsp_acc_cnt == trips_queued);
      @(negedge clock);
   endtask

   task automatic write_mask(logic [MASK_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do begin
         @(posedge clock);
      end while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // drive requests: one transfer per queued trip, random gap before each
   always @(negedge clock) begin
      logic offer;
      offer = req_tvalid;
      if (req_acc_cnt != req_seen) begin
         req_seen = req_acc_cnt;
         offer    = 1'b0;
         if ($urandom_range(0, 19) == 0) begin
            send_steady = !send_steady;
         end
         send_gap = send_steady ? 0 : $urandom_range(0, 9);
      end
      if (!offer && !reset) begin
         if (send_gap > 0) begin
            send_gap--;
         end else if (pending_trips.size() > 0) begin
            req_tdata <= {2'b00, pending_trips.pop_front()};
            offer = 1'b1;
         end
      end
      req_tvalid <= offer;
   end

   // drive rsp_tready: random stall per result, plus the long hold-off
   always @(negedge clock) begin
      logic take;
      if (rsp_acc_cnt != rsp_seen) begin
         rsp_seen = rsp_acc_cnt;
         if ($urandom_range(0, 19) == 0) begin
            recv_steady = !recv_steady;
         end
         recv_wait = recv_steady ? 0 : $urandom_range(0, 9);
      end
      take = !rsp_hold && recv_wait == 0;
      if (!take && !rsp_hold && rsp_tvalid) begin
         recv_wait--;
      end
      rsp_tready <= take;
   end

   // sample transfers, predict and check
   always @(posedge clock) begin
      landing_type got;
      landing_type want;
      bit          moved;
      moved = 1'b0;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            mask_now = csr_data;
            moved    = 1'b1;
         end
         if (rsp_tvalid && rsp_tready) begin
            rsp_acc_cnt++;
            moved = 1'b1;
            got   = {rsp_tuser, rsp_tdata[25:0]};
            if (expected_landings.size() == 0) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS) begin
                  $display("unexpected result %0d-%0d-%0d wd %0d err %0d",
                           got.year, got.month, got.day, got.weekday, got.err);
               end
            end else begin
               want = expected_landings.pop_front();
               if (got.year !== want.year || got.month !== want.month ||
                   got.day !== want.day || got.weekday !== want.weekday ||
                   got.err !== want.err) begin
                  fail_count++;
                  if (fail_count <= MAX_REPORTS) begin
                     $display("result %0d: exp %0d-%0d-%0d wd %0d err %0d, got %0d-%0d-%0d",
                              rsp_acc_cnt, want.year, want.month, want.day, want.weekday,
                              want.err, got.year, got.month, got.day);
                     $display("   got wd %0d err %0d", got.weekday, got.err);
                  end
               end
            end
         end
         if (req_tvalid && req_tready) begin
            req_acc_cnt++;
            moved = 1'b1;
            expected_landings.push_back(
               predict_landing(trip_type'(req_tdata[37:0]), mask_now));
         end
         quiet_cycles = moved ? 0 : quiet_cycles + 1;
      end
   end

   // watchdog: too long without any transfer
   initial begin
      wait (quiet_cycles >= STALL_LIMIT);
      $display("tb_business_day_date_adder_unit: done, errors");
      $finish;
   end

   // receiver hold-off while the sender keeps offering, so the block backs up
   initial begin
      wait (req_acc_cnt >= 40);
      @(posedge clock);
      rsp_hold = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold = 1'b0;
   end

   // stimulus phases
   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // calendar corners under the reset weekend (Friday, Saturday)
      queue_trip(2024, 1, 15, 10);
      queue_trip(1, 1, 1, 0);
      queue_trip(1, 1, 1, 1);
      queue_trip(2000, 2, 28, 3);
      queue_trip(1900, 2, 28, 3);
      queue_trip(2024, 2, 29, 0);
      queue_trip(2024, 6, 14, 0);
      queue_trip(2024, 12, 31, 1);
      queue_trip(9999, 12, 31, 5);
      queue_trip(10000, 2, 29, 1);
      queue_trip(16383, 1, 1, 200);
      queue_trip(16383, 12, 25, 10);
      queue_trip(16383, 12, 31, 0);
      queue_trip(16383, 12, 31, 1);
      queue_trip(2023, 2, 29, 5);
      queue_trip(0, 5, 5, 3);
      queue_trip(2024, 0, 10, 3);
      queue_trip(2024, 13, 1, 3);
      queue_trip(16383, 15, 31, 32767);
      queue_trip(2024, 4, 31, 2);
      queue_trip(2024, 4, 0, 2);
      queue_trip(2024, 3, 1, 32767);
      queue_random(120);
      settle();

      // no weekend at all
      write_mask(7'h00);
      queue_random(100);
      settle();

      // every day weekend: bad date still wins over the empty week
      write_mask(MASK_ALL);
      queue_trip(2024, 2, 30, 4);
      queue_trip(2024, 1, 1, 4);
      queue_random(30);
      settle();

      // only Sunday and Saturday working
      write_mask(7'h3E);
      queue_random(100);
      settle();

      // only Saturday working
      write_mask(7'h3F);
      queue_random(80);
      settle();

      // arbitrary masks
      repeat (2) begin
         write_mask(MASK_W'($urandom_range(0, 127)));
         queue_random(80);
         settle();
      end

      repeat (30) @(posedge clock);
      if (fail_count == 0 && expected_landings.size() == 0) begin
         $display("tb_business_day_date_adder_unit: done, clean");
      end else begin
         $display("tb_business_day_date_adder_unit: done, errors");
      end
      $finish;
   end

endmodule

`default_nettype wire

>>> files.f
design/bdda_pkg.sv
design/bdda_day_step.sv
design/business_day_date_adder_unit.sv
tb/tb_business_day_date_adder_unit.sv
